// ===== src/multichannel_moving_average_rms_macros.svh =====
// assertion macros for the multichannel moving average / rms block
// used by the port checker; expects clk and rst_n in scope
`ifndef MULTICHANNEL_MOVING_AVERAGE_RMS_MACROS_SVH
`define MULTICHANNEL_MOVING_AVERAGE_RMS_MACROS_SVH

// same-cycle implication, disabled in reset
`define MMAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define MMAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mmar_pkg.sv =====
// shared types and constants for the multichannel moving average / rms block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mmar_pkg;

    // defaults for the top level parameters
    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_MAX_WINDOW = 2048;
    localparam int RESET_WINDOW   = 100;

    // field widths; a squared full-scale sample needs a signed ring entry
    // of 32 bits, and its sum over the deepest window needs 43 bits
    localparam int CH_BITS    = 3;
    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 2;
    localparam int WIN_W      = 12;
    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 43;
    localparam int RAD_W      = 32;
    localparam int ROOT_W     = 16;

    // iteration counts of the shared units
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = 6;

    // register indexes
    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    // averaging modes
    localparam logic [MODE_W-1:0] MODE_BIPOLAR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ABSOLUTE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RMS      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic div_step;
        logic post;
        logic sqrt_step;
        logic out_load;
        logic clear_step;
    } mmar_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ch_ok;
        logic rms;
        logic clear_last;
        logic out_free;
    } mmar_status_t;

endpackage

`default_nettype wire

// ===== src/mmar_ctrl.sv =====
// controller state machine for the moving average / rms block
// depends on mmar_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmar_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    input  wire                   cfg_we,
    input  mmar_pkg::mmar_status_t status,
    output logic                  in_ready,
    output mmar_pkg::mmar_cmd_t   cmd
);
    import mmar_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_POST   = 3'd5;
    localparam logic [2:0] S_SQRT   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    assign in_ready = (state_reg == S_IDLE) && !cfg_we;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                if (cfg_we)
                begin
                    state_next = S_CLEAR;
                end
                else
                begin
                    cmd.clear_step = 1'b1;
                    if (status.clear_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_CLEAR;
                end
                else if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                if (status.ch_ok)
                begin
                    cmd.read   = 1'b1;
                    state_next = S_UPDATE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                cmd.post   = 1'b1;
                step_next  = '0;
                state_next = status.rms ? S_SQRT : S_DONE;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/mmar_datapath.sv =====
// datapath: config registers, sums, sample ring memory, divider, square root
// depends on mmar_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmar_datapath #(
    parameter int CHANNELS   = mmar_pkg::DEF_CHANNELS,
    parameter int MAX_WINDOW = mmar_pkg::DEF_MAX_WINDOW
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire                                  cfg_index,
    input  wire  [mmar_pkg::WIN_W-1:0]           cfg_data,
    input  wire  [mmar_pkg::CH_BITS-1:0]         channel,
    input  wire  signed [mmar_pkg::SAMPLE_W-1:0] sample,
    input  wire                                  out_ready,
    input  mmar_pkg::mmar_cmd_t                  cmd,
    output mmar_pkg::mmar_status_t               status,
    output logic                                 out_valid,
    output logic [mmar_pkg::CH_BITS-1:0]         out_channel,
    output logic signed [mmar_pkg::SAMPLE_W-1:0] average
);
    import mmar_pkg::*;

    localparam int DEPTH  = CHANNELS * MAX_WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(MAX_WINDOW);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration and per-channel state
    logic [MODE_W-1:0]        mode_reg;
    logic [WIN_W-1:0]         win_reg;
    logic [ADDR_W-1:0]        clr_cnt_reg;
    logic signed [SUM_W-1:0]  sum_reg [CHANNELS];
    logic [POS_W-1:0]         pos_reg [CHANNELS];

    // request payload and work registers
    logic [CH_BITS-1:0]         ch_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [POS_W-1:0]           pos_use_reg;
    logic signed [VALUE_W-1:0]  rd_reg;
    logic [SUM_W-1:0]           dvd_reg;
    logic [WIN_W-1:0]           rem_reg;
    logic                       neg_reg;
    logic signed [SAMPLE_W-1:0] result_reg;
    logic [RAD_W-1:0]           rad_reg;
    logic [ROOT_W-1:0]          root_reg;
    logic [ROOT_W:0]            srem_reg;

    // output register
    logic                       out_valid_reg;
    logic [CH_BITS-1:0]         out_channel_reg;
    logic signed [SAMPLE_W-1:0] average_reg;

    logic signed [VALUE_W-1:0]  mem [DEPTH];

    logic [CH_W-1:0]            ch_idx;
    logic [WIN_W-1:0]           win_clip;
    logic signed [VALUE_W-1:0]  value_c;
    logic signed [VALUE_W-1:0]  s_ext;
    logic signed [2*SAMPLE_W-1:0] sq_c;
    logic [POS_W-1:0]           pos_cur;
    logic [POS_W:0]             pos_inc;
    logic [POS_W-1:0]           pos_nxt;
    logic [ADDR_W-1:0]          addr_c;
    logic signed [SUM_W-1:0]    sum_new;
    logic [WIN_W:0]             rem_sh;
    logic [WIN_W:0]             win_ext;
    logic                       div_ge;
    logic signed [SUM_W:0]      mean_c;
    logic signed [SAMPLE_W-1:0] clamp_c;
    logic [RAD_W-1:0]           rad_c;
    logic [ROOT_W+2:0]          srem_sh;
    logic [ROOT_W+2:0]          trial;
    logic                       sqrt_ge;
    logic                       clear_last;

    assign ch_idx     = CH_W'(ch_reg);
    assign clear_last = (32'(clr_cnt_reg) == DEPTH - 1);

    // window length clipping on write
    always_comb
    begin
        if (cfg_data == '0)
            win_clip = WIN_W'(1);
        else if (32'(cfg_data) > MAX_WINDOW)
            win_clip = WIN_W'(MAX_WINDOW);
        else
            win_clip = cfg_data;
    end

    // sample transform by mode
    assign s_ext = VALUE_W'(sample);
    assign sq_c  = sample * sample;
    always_comb
    begin
        case (mode_reg)
            MODE_ABSOLUTE: value_c = sample[SAMPLE_W-1] ? -s_ext : s_ext;
            MODE_RMS:      value_c = sq_c;
            default:       value_c = s_ext;
        endcase
    end

    // ring position and address
    always_comb
    begin
        pos_cur = pos_reg[ch_idx];
        if (32'(pos_cur) >= 32'(win_reg))
            pos_cur = '0;
        pos_inc = {1'b0, pos_use_reg} + 1'b1;
        pos_nxt = (32'(pos_inc) >= 32'(win_reg)) ? '0 : POS_W'(pos_inc);
    end
    assign addr_c  = ADDR_W'(32'(ch_idx) * MAX_WINDOW + 32'(pos_cur));
    assign sum_new = sum_reg[ch_idx] - SUM_W'(rd_reg) + SUM_W'(value_reg);

    // divider step
    assign rem_sh  = {rem_reg, dvd_reg[SUM_W-1]};
    assign win_ext = {1'b0, win_reg};
    assign div_ge  = (rem_sh >= win_ext);

    // signed mean, clamp and radicand
    always_comb
    begin
        mean_c = neg_reg ? -$signed({1'b0, dvd_reg}) : $signed({1'b0, dvd_reg});
        if (mean_c > (SUM_W+1)'(32767))
            clamp_c = 16'sh7FFF;
        else if (mean_c < -(SUM_W+1)'(32768))
            clamp_c = 16'sh8000;
        else
            clamp_c = mean_c[SAMPLE_W-1:0];
        if (mean_c[SUM_W])
            rad_c = '0;
        else if (|mean_c[SUM_W-1:RAD_W])
            rad_c = '1;
        else
            rad_c = mean_c[RAD_W-1:0];
    end

    // square root step
    assign srem_sh = {srem_reg, rad_reg[RAD_W-1:RAD_W-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign sqrt_ge = (srem_sh >= trial);

    // config, sums, positions and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_BIPOLAR;
            win_reg     <= WIN_W'(RESET_WINDOW);
            clr_cnt_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_MODE)
                mode_reg <= cfg_data[MODE_W-1:0];
            else
                win_reg <= win_clip;
            clr_cnt_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.clear_step && !clear_last)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.update)
            begin
                sum_reg[ch_idx] <= sum_new;
                pos_reg[ch_idx] <= pos_nxt;
            end
        end
    end

    // sample ring memory
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[clr_cnt_reg] <= '0;
        else if (cmd.update)
            mem[addr_reg] <= value_reg;
        if (cmd.read)
            rd_reg <= mem[addr_c];
    end

    // request payload, divider and square root
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg     <= channel;
            value_reg  <= value_c;
            result_reg <= '0;
        end
        if (cmd.read)
        begin
            addr_reg    <= addr_c;
            pos_use_reg <= pos_cur;
        end
        if (cmd.update)
        begin
            dvd_reg <= sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
            neg_reg <= sum_new[SUM_W-1];
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= div_ge ? WIN_W'(rem_sh - win_ext) : rem_sh[WIN_W-1:0];
            dvd_reg <= {dvd_reg[SUM_W-2:0], div_ge};
        end
        if (cmd.post)
        begin
            result_reg <= clamp_c;
            rad_reg    <= rad_c;
            root_reg   <= '0;
            srem_reg   <= '0;
        end
        if (cmd.sqrt_step)
        begin
            srem_reg <= sqrt_ge ? (ROOT_W+1)'(srem_sh - trial) : srem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], sqrt_ge};
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_channel_reg <= ch_reg;
            if (mode_reg == MODE_RMS && status.ch_ok)
                average_reg <= root_reg[ROOT_W-1] ? 16'sh7FFF : $signed(root_reg);
            else
                average_reg <= result_reg;
        end
    end

    assign status.ch_ok      = (32'(ch_reg) < CHANNELS);
    assign status.rms        = (mode_reg == MODE_RMS);
    assign status.clear_last = clear_last;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign average     = average_reg;

endmodule

`default_nettype wire

// ===== src/multichannel_moving_average_rms.sv =====
// the divider takes 43 steps at one quotient bit a cycle, and rms mode
// adds a 16-step square root; one request is worked on at a time, and
// a finished result waits in the output register while the next request
// is taken; reset and every config write clear sums, and reset or a
// config write while idle or clearing starts a ring clearing pass over
// all CHANNELS*MAX_WINDOW entries (16384 by default) with in_ready low
`timescale 1ns / 1ps
`default_nettype none

module multichannel_moving_average_rms #(
    parameter int CHANNELS   = mmar_pkg::DEF_CHANNELS,
    parameter int MAX_WINDOW = mmar_pkg::DEF_MAX_WINDOW
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire                                  cfg_index,
    input  wire  [mmar_pkg::WIN_W-1:0]           cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  [mmar_pkg::CH_BITS-1:0]         channel,
    input  wire  signed [mmar_pkg::SAMPLE_W-1:0] sample,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [mmar_pkg::CH_BITS-1:0]         out_channel,
    output logic signed [mmar_pkg::SAMPLE_W-1:0] average
);
    import mmar_pkg::*;

    mmar_cmd_t    cmd;
    mmar_status_t status;

    // controller
    mmar_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // datapath
    mmar_datapath #(
        .CHANNELS   (CHANNELS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .channel     (channel),
        .sample      (sample),
        .out_ready   (out_ready),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_channel (out_channel),
        .average     (average)
    );

endmodule

`default_nettype wire

// ===== src/mmar_checker.sv =====
// port level checker for the moving average / rms block, bound to the top
// depends on mmar_pkg and multichannel_moving_average_rms_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_moving_average_rms_macros.svh"

module mmar_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           cfg_we,
    input wire                           in_valid,
    input wire                           in_ready,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire [mmar_pkg::CH_BITS-1:0]   out_channel,
    input wire [mmar_pkg::SAMPLE_W-1:0]  average
);

    // a stalled result stays offered
    `MMAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // one request at a time: ready drops after a request is taken
    `MMAR_ASSERT_NEXT(a_one_busy, in_valid && in_ready, !in_ready, "ready high right after request")

    // a config write between requests starts the clearing pass
    `MMAR_ASSERT_NEXT(a_cfg_clear, cfg_we, !in_ready, "ready high right after config write")

    // a stalled result keeps its payload
    `MMAR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_channel) && $stable(average), "result changed while stalled")

endmodule

bind multichannel_moving_average_rms mmar_checker u_mmar_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_channel (out_channel),
    .average     (average)
);

`default_nettype wire

// ===== sim/tb_multichannel_moving_average_rms.sv =====
// testbench for the multichannel moving average / rms block
// self-checking: a behavioral predictor checks every result in order
// depends on mmar_pkg and multichannel_moving_average_rms
`timescale 1ns / 1ps

module tb_multichannel_moving_average_rms;
    import mmar_pkg::*;

    localparam int NCH = DEF_CHANNELS;
    localparam int MAXW = DEF_MAX_WINDOW;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 100;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [CH_BITS-1:0]         ch;
        logic signed [SAMPLE_W-1:0] avg;
    } avg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = 1'b0;
    logic [WIN_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CH_BITS-1:0] channel = '0;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CH_BITS-1:0] out_channel;
    logic signed [SAMPLE_W-1:0] average;

    // predictor state
    logic [MODE_W-1:0] avg_mode;
    int                win_len;
    longint            chan_sum [NCH];
    int                win_ring [NCH*MAXW];
    int                wr_pos   [NCH];

    avg_result_t expected_avg_q[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  err_count = 0;
    longint cycle_count = 0;

    multichannel_moving_average_rms u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .average     (average)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multichannel_moving_average_rms: mismatch");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        avg_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_avg_q.size() == 0)
            begin
                $error("unexpected result: out_channel %0d average %0d", out_channel, average);
                err_count++;
            end
            else
            begin
                exp_r = expected_avg_q.pop_front();
                if (out_channel !== exp_r.ch)
                begin
                    $error("out_channel: expected %0d actual %0d", exp_r.ch, out_channel);
                    err_count++;
                end
                if (average !== exp_r.avg)
                begin
                    $error("average: expected %0d actual %0d", exp_r.avg, average);
                    err_count++;
                end
            end
        end
    end

    // zero all sums, rings and write positions
    function automatic void clear_windows();
        foreach (chan_sum[i]) chan_sum[i] = 0;
        foreach (win_ring[i]) win_ring[i] = 0;
        foreach (wr_pos[i]) wr_pos[i] = 0;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        return root;
    endfunction

    // windowed mean or rms of one channel after taking a sample
    function automatic avg_result_t window_average(logic [CH_BITS-1:0] ch,
                                                   logic signed [SAMPLE_W-1:0] s);
        avg_result_t r;
        int pos;
        int slot;
        int val;
        int sv;
        longint mean;
        longint unsigned root;
        sv = int'(s);
        r.ch = ch;
        pos = wr_pos[ch];
        if (pos >= win_len) pos = 0;
        slot = int'(ch) * MAXW + pos;
        if (avg_mode == MODE_ABSOLUTE) val = (sv < 0) ? -sv : sv;
        else if (avg_mode == MODE_RMS) val = sv * sv;
        else val = sv;
        chan_sum[ch] -= win_ring[slot];
        win_ring[slot] = val;
        chan_sum[ch] += val;
        pos++;
        if (pos >= win_len) pos = 0;
        wr_pos[ch] = pos;
        mean = chan_sum[ch] / longint'(win_len);
        if (avg_mode == MODE_RMS)
        begin
            root = floor_root((mean < 0) ? 64'd0 : unsigned'(mean));
            r.avg = (root > 32767) ? 16'sd32767 : root[15:0];
        end
        else
        begin
            if (mean > 32767) mean = 32767;
            if (mean < -32768) mean = -32768;
            r.avg = mean[15:0];
        end
        return r;
    endfunction

    // send one request; in_valid stays high for the caller to lower
    task automatic send_sample(logic [CH_BITS-1:0] ch, logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        channel  <= ch;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_avg_q.push_back(window_average(ch, s));
    endtask

    // register write once all results are in and the block is quiet
    task automatic write_reg(logic idx, logic [WIN_W-1:0] data);
        int w;
        in_valid <= 1'b0;
        while (expected_avg_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE)
            avg_mode = data[MODE_W-1:0];
        else
        begin
            w = int'(data);
            if (w < 1) w = 1;
            if (w > MAXW) w = MAXW;
            win_len = w;
        end
        clear_windows();
    endtask

    // extremes under every mode, saturation and window clipping
    task automatic test_directed();
        send_sample(3'd0, 16'sd32767);
        send_sample(3'd7, -16'sd32768);
        send_sample(3'd3, 16'sd0);
        write_reg(REG_WINDOW, 12'd0);
        write_reg(REG_MODE, WIN_W'(MODE_ABSOLUTE));
        send_sample(3'd1, -16'sd32768);
        send_sample(3'd1, 16'sd32767);
        send_sample(3'd2, -16'sd1);
        write_reg(REG_MODE, WIN_W'(MODE_RMS));
        send_sample(3'd4, -16'sd32768);
        send_sample(3'd4, 16'sd32767);
        send_sample(3'd5, 16'sd1);
        send_sample(3'd5, -16'sd2);
        write_reg(REG_MODE, WIN_W'(MODE_UNUSED));
        send_sample(3'd6, -16'sd32768);
        send_sample(3'd6, 16'sd12345);
        write_reg(REG_WINDOW, 12'd4095);
        send_sample(3'd0, -16'sd32768);
        send_sample(3'd0, 16'sd32767);
        write_reg(REG_MODE, WIN_W'(MODE_BIPOLAR));
        write_reg(REG_WINDOW, 12'd2048);
        send_sample(3'd7, 16'sd32767);
        send_sample(3'd7, 16'sd100);
        write_reg(REG_WINDOW, 12'd1);
        send_sample(3'd2, 16'sd32767);
        send_sample(3'd2, -16'sd32768);
    endtask

    // random traffic over several settings, mostly short windows
    task automatic test_random(int n_items, int idle_pct, int stall_pct);
        int per;
        logic signed [SAMPLE_W-1:0] s;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        per = n_items / 4;
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_MODE, WIN_W'($urandom_range(3)));
            if ($urandom_range(9) == 0)
                write_reg(REG_WINDOW, WIN_W'($urandom_range(4095)));
            else
                write_reg(REG_WINDOW, WIN_W'($urandom_range(1, 16)));
            for (int i = 0; i < per; i++)
            begin
                case ($urandom_range(7))
                    0: s = 16'sh7fff;
                    1: s = 16'sh8000;
                    2: s = SAMPLE_W'($urandom_range(7) - 4);
                    default: s = SAMPLE_W'($urandom());
                endcase
                send_sample(CH_BITS'($urandom_range(NCH - 1)), s);
            end
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        avg_mode = MODE_BIPOLAR;
        win_len  = RESET_WINDOW;
        clear_windows();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(544, 8, 64);
        test_random(544, 64, 8);
        test_random(544, 0, 0);
        while (expected_avg_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("multichannel_moving_average_rms: match");
        else
            $display("multichannel_moving_average_rms: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/mmar_pkg.sv
src/mmar_ctrl.sv
src/mmar_datapath.sv
src/multichannel_moving_average_rms.sv
src/mmar_checker.sv
sim/tb_multichannel_moving_average_rms.sv
